// ===== hdl/bvzm_pkg.sv =====
// Package for the battery voltage zone monitor.
// Zone and event codes, register indexes, threshold bundle and counter sizes.
// No dependencies.
`default_nettype none

package bvzm_pkg;

  localparam int MvW         = 16;
  localparam int RETRY_LIMIT = 5;
  localparam int FailW       = $clog2(RETRY_LIMIT + 1);
  localparam int NumZones    = 4;

  typedef enum logic [1:0] {
    ZONE_NORMAL = 2'd0,
    ZONE_LOW    = 2'd1,
    ZONE_HIGH   = 2'd2,
    ZONE_OFF    = 2'd3
  } zone_e;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_LOW       = 3'd1,
    EV_HIGH      = 3'd2,
    EV_OFF       = 3'd3,
    EV_RECOVERED = 3'd4,
    EV_HALTED    = 3'd5
  } event_e;

  typedef enum logic [1:0] {
    REG_LOW_THR  = 2'd0,
    REG_HIGH_THR = 2'd1,
    REG_OFF_THR  = 2'd2
  } reg_idx_e;

  typedef logic [1:0] cnt_t;

  // samples needed to confirm a zone
  localparam cnt_t ConfirmCount    = 2'd3;
  localparam cnt_t OffConfirmCount = 2'd2;

  localparam logic [MvW-1:0] LowThrReset  = 16'd11500;
  localparam logic [MvW-1:0] HighThrReset = 16'd14400;
  localparam logic [MvW-1:0] OffThrReset  = 16'd10500;

  typedef struct packed {
    logic [MvW-1:0] low_mv;
    logic [MvW-1:0] high_mv;
    logic [MvW-1:0] off_mv;
  } thr_t;

endpackage

`default_nettype wire

// ===== hdl/bvzm_zone_sort.sv =====
// Sorts one voltage sample into its zone against the three thresholds.
// Depends on bvzm_pkg.
`default_nettype none

module bvzm_zone_sort
  import bvzm_pkg::*;
(
  input  thr_t           thr_i,
  input  logic [MvW-1:0] sample_mv_i,
  output zone_e          zone_o
);

  logic below_low, above_off, above_high, below_off;

  assign below_low  = sample_mv_i < thr_i.low_mv;
  assign above_off  = sample_mv_i > thr_i.off_mv;
  assign above_high = sample_mv_i > thr_i.high_mv;
  assign below_off  = sample_mv_i < thr_i.off_mv;

  // priority: low, high, off, normal (a sample equal to off threshold is normal)
  always_comb begin
    if (below_low && above_off) begin
      zone_o = ZONE_LOW;
    end else if (above_high) begin
      zone_o = ZONE_HIGH;
    end else if (below_off) begin
      zone_o = ZONE_OFF;
    end else begin
      zone_o = ZONE_NORMAL;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/battery_voltage_zone_monitor.sv =====
// Top level of the battery voltage zone monitor: threshold registers, zone
// counters, latch, retry counter and the result register.
// Depends on bvzm_pkg and bvzm_zone_sort.
`default_nettype none

// Takes one read attempt per cycle and returns one result per attempt, in the
// cycle after it is accepted. All work for an attempt is done in a single
// pass from the input port into the result register; the input is stalled
// only while a result is held by a stalled output, so with out_stall_i low
// the throughput is one transaction per clock. A zone is confirmed on its
// third consecutive-in-count sample (second for supply off); an event is
// reported only when the latched zone changes or on halt. After RETRY_LIMIT
// tolerated failed reads, the next failed read reports halted and all later inputs
// return the held zone with monitor_halted_o set. The user must write thresholds
// through the cfg port only while idle (not enforced); cfg_ready_o is always high.
module battery_voltage_zone_monitor
  import bvzm_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,

  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [1:0]     cfg_index_i,
  input  logic [MvW-1:0] cfg_data_i,

  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic           read_ok_i,
  input  logic [MvW-1:0] sample_mv_i,

  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [2:0]     event_code_o,
  output logic           cancel_shutdown_o,
  output logic [1:0]     latched_zone_o,
  output logic           monitor_halted_o
);

  thr_t thr_q;

  cnt_t             cnt_q [NumZones];
  cnt_t             cnt_d [NumZones];
  zone_e            latch_q, latch_d;
  logic [FailW-1:0] fail_q, fail_d;
  logic             halted_q, halted_d;

  logic             out_valid_q;
  event_e           ev_q, ev_d;
  logic             cancel_q, cancel_d;

  zone_e            zone;
  cnt_t             cnt_inc;
  logic             confirm;
  logic             accept;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;

  // threshold registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.low_mv  <= LowThrReset;
      thr_q.high_mv <= HighThrReset;
      thr_q.off_mv  <= OffThrReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_LOW_THR:  thr_q.low_mv  <= cfg_data_i;
        REG_HIGH_THR: thr_q.high_mv <= cfg_data_i;
        REG_OFF_THR:  thr_q.off_mv  <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  bvzm_zone_sort u_zone_sort (
    .thr_i       (thr_q),
    .sample_mv_i (sample_mv_i),
    .zone_o      (zone)
  );

  assign cnt_inc = cnt_q[zone] + 2'd1;
  assign confirm = (zone == ZONE_OFF) ? (cnt_inc >= OffConfirmCount)
                                      : (cnt_inc >= ConfirmCount);

  always_comb begin
    cnt_d    = cnt_q;
    latch_d  = latch_q;
    fail_d   = fail_q;
    halted_d = halted_q;
    ev_d     = EV_NONE;
    cancel_d = 1'b0;
    if (!halted_q) begin
      if (!read_ok_i) begin
        if (fail_q >= FailW'(RETRY_LIMIT)) begin
          halted_d = 1'b1;
          ev_d     = EV_HALTED;
        end else begin
          fail_d = fail_q + FailW'(1);
        end
      end else begin
        fail_d = '0;
        if (confirm) begin
          for (int i = 0; i < NumZones; i++) begin
            cnt_d[i] = '0;
          end
          if (latch_q != zone) begin
            latch_d = zone;
            case (zone)
              ZONE_LOW:  ev_d = EV_LOW;
              ZONE_HIGH: ev_d = EV_HIGH;
              ZONE_OFF:  ev_d = EV_OFF;
              default: begin
                ev_d     = EV_RECOVERED;
                cancel_d = (latch_q == ZONE_LOW);
              end
            endcase
          end
        end else begin
          cnt_d[zone] = cnt_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumZones; i++) begin
        cnt_q[i] <= '0;
      end
      latch_q  <= ZONE_NORMAL;
      fail_q   <= '0;
      halted_q <= 1'b0;
    end else if (accept) begin
      cnt_q    <= cnt_d;
      latch_q  <= latch_d;
      fail_q   <= fail_d;
      halted_q <= halted_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ev_q     <= ev_d;
      cancel_q <= cancel_d;
    end
  end

  // latch and halt state are only touched on accept, so they match the held result
  assign out_valid_o       = out_valid_q;
  assign event_code_o      = ev_q;
  assign cancel_shutdown_o = cancel_q;
  assign latched_zone_o    = latch_q;
  assign monitor_halted_o  = halted_q;

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halt state cleared");

  a_fail_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fail_q <= FailW'(RETRY_LIMIT))
    else $error("failed read count beyond limit");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[ZONE_OFF] < OffConfirmCount && cnt_q[ZONE_LOW] < ConfirmCount &&
    cnt_q[ZONE_HIGH] < ConfirmCount && cnt_q[ZONE_NORMAL] < ConfirmCount)
    else $error("zone counter not cleared on confirm");

  a_cancel_recover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && cancel_q |-> ev_q == EV_RECOVERED && latch_q == ZONE_NORMAL)
    else $error("shutdown cancel without recovery");

  a_halt_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && ev_d == EV_HALTED |=> halted_q && out_valid_q)
    else $error("halt event without halt state");

endmodule

`default_nettype wire
